// ===== src/write_fragment_coalescer_core_assert.svh =====
// Assertion helpers for the coalescer; clk and rst come from the using module.
`ifndef WRITE_FRAGMENT_COALESCER_CORE_ASSERT_SVH
`define WRITE_FRAGMENT_COALESCER_CORE_ASSERT_SVH

// same-cycle implication
`define WFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfc check failed");

// next-cycle implication
`define WFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfc sequencing check failed");

`endif

// ===== src/wfc_pkg.sv =====
package wfc_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CNT_W = 5;
  localparam logic [4:0] THRESH_RESET = 5'd8;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] frag_offset;
    logic [31:0] frag_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] run_offset;
    logic [31:0] run_length;
    logic [4:0]  run_count;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHK,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_FL_INIT,
    ST_FL_PICK,
    ST_FL_MERGE,
    ST_FL_TAIL,
    ST_FL_DONE,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       ins_write;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       set_miss;
    logic       idx_top;
    logic       idx_dec;
    logic       rm_shift;
    logic       pick_clear;
    logic       pick_init;
    logic       pick_step;
    logic       merge;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       idx_zero;
    logic       match;
    logic       reach_thr;
    logic       shift_more;
    logic       run_emit;
    logic       run_pending;
    logic       last_pick;
    logic       out_free;
  } status_t;

endpackage

// ===== src/wfc_ctrl.sv =====
module wfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  wfc_pkg::status_t stat,
  output wfc_pkg::cmd_t    cmd
);

  wfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != wfc_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      wfc_pkg::ST_IDLE: if (in_valid) state_next = wfc_pkg::ST_DISPATCH;
      wfc_pkg::ST_DISPATCH: begin
        case (stat.func)
          wfc_pkg::FUNC_INSERT: state_next = wfc_pkg::ST_INS_CHK;
          wfc_pkg::FUNC_REMOVE:
            state_next = stat.cnt_zero ? wfc_pkg::ST_ACK : wfc_pkg::ST_RM_SCAN;
          wfc_pkg::FUNC_FLUSH: state_next = wfc_pkg::ST_FL_INIT;
          default: state_next = wfc_pkg::ST_ACK;
        endcase
      end
      wfc_pkg::ST_INS_CHK:
        state_next = stat.reach_thr ? wfc_pkg::ST_FL_INIT : wfc_pkg::ST_ACK;
      wfc_pkg::ST_RM_SCAN: begin
        if (stat.match) state_next = wfc_pkg::ST_RM_SHIFT;
        else if (stat.idx_zero) state_next = wfc_pkg::ST_ACK;
      end
      wfc_pkg::ST_RM_SHIFT: if (!stat.shift_more) state_next = wfc_pkg::ST_ACK;
      wfc_pkg::ST_FL_INIT:
        state_next = stat.cnt_zero ? wfc_pkg::ST_FL_DONE : wfc_pkg::ST_FL_PICK;
      wfc_pkg::ST_FL_PICK: if (stat.idx_zero) state_next = wfc_pkg::ST_FL_MERGE;
      wfc_pkg::ST_FL_MERGE: begin
        if (!stat.run_emit || stat.out_free) begin
          state_next = stat.last_pick ? wfc_pkg::ST_FL_TAIL : wfc_pkg::ST_FL_PICK;
        end
      end
      wfc_pkg::ST_FL_TAIL: begin
        if (!stat.run_pending || stat.out_free) state_next = wfc_pkg::ST_FL_DONE;
      end
      wfc_pkg::ST_FL_DONE: if (stat.out_free) state_next = wfc_pkg::ST_IDLE;
      wfc_pkg::ST_ACK: if (stat.out_free) state_next = wfc_pkg::ST_IDLE;
      default: state_next = wfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      wfc_pkg::ST_IDLE: cmd.latch = in_valid;
      wfc_pkg::ST_DISPATCH: begin
        cmd.ins_write = (stat.func == wfc_pkg::FUNC_INSERT);
        cmd.idx_top   = (stat.func == wfc_pkg::FUNC_REMOVE);
        cmd.set_miss  = (stat.func == wfc_pkg::FUNC_REMOVE) && stat.cnt_zero;
      end
      wfc_pkg::ST_RM_SCAN: begin
        cmd.idx_dec  = !stat.match && !stat.idx_zero;
        cmd.set_miss = !stat.match && stat.idx_zero;
      end
      wfc_pkg::ST_RM_SHIFT: begin
        cmd.rm_shift = stat.shift_more;
        cmd.cnt_dec  = !stat.shift_more;
      end
      wfc_pkg::ST_FL_INIT: begin
        cmd.pick_clear = 1'b1;
        cmd.pick_init  = 1'b1;
      end
      wfc_pkg::ST_FL_PICK: begin
        cmd.pick_step = 1'b1;
        cmd.idx_dec   = !stat.idx_zero;
      end
      wfc_pkg::ST_FL_MERGE: begin
        if (!stat.run_emit || stat.out_free) begin
          cmd.merge     = 1'b1;
          cmd.pick_init = !stat.last_pick;
          cmd.emit      = stat.run_emit;
          cmd.emit_kind = wfc_pkg::KIND_RUN;
        end
      end
      wfc_pkg::ST_FL_TAIL: begin
        cmd.emit      = stat.run_pending && stat.out_free;
        cmd.emit_kind = wfc_pkg::KIND_RUN;
      end
      wfc_pkg::ST_FL_DONE: begin
        cmd.emit      = stat.out_free;
        cmd.cnt_clr   = stat.out_free;
        cmd.emit_kind = wfc_pkg::KIND_DONE;
        cmd.emit_last = 1'b1;
      end
      wfc_pkg::ST_ACK: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = wfc_pkg::KIND_ACK;
        cmd.emit_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/wfc_datapath.sv =====
module wfc_datapath #(
  parameter int DEPTH = wfc_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  wfc_pkg::in_item_t  in_item,
  input  logic               out_stall,
  output logic               out_valid,
  output wfc_pkg::out_item_t out_item,
  input  wfc_pkg::cmd_t      cmd,
  output wfc_pkg::status_t   stat
);

  localparam int HoldMax = (DEPTH < 16) ? DEPTH : 16;
  localparam int IdxW = $clog2(HoldMax);
  localparam int CW = wfc_pkg::CNT_W;
  localparam logic [CW-1:0] HoldMaxC = CW'(HoldMax);

  logic [4:0]          threshold;
  wfc_pkg::in_item_t   cur;
  logic [CW-1:0]       count;
  logic                miss;
  logic [IdxW-1:0]     idx;
  logic [31:0]         offs  [HoldMax];
  logic [31:0]         sizes [HoldMax];
  logic [HoldMax-1:0]  consumed;
  logic [CW-1:0]       npick;
  logic                cand_valid;
  logic [IdxW-1:0]     cand_idx;
  logic [31:0]         cand_off;
  logic [31:0]         cand_size;
  logic [31:0]         left;
  logic [31:0]         right;
  logic [CW-1:0]       run_cnt;

  logic [CW-1:0]   thr_lo, eff_thr;
  logic [IdxW-1:0] idx1;
  logic [31:0]     rd_off, rd_size;
  logic            better, chain, out_free;

  assign thr_lo   = (threshold == '0) ? CW'(1) : threshold;
  assign eff_thr  = (thr_lo > HoldMaxC) ? HoldMaxC : thr_lo;
  assign idx1     = idx + IdxW'(1);
  assign rd_off   = offs[idx];
  assign rd_size  = sizes[idx];
  assign better   = !consumed[idx] && (!cand_valid || rd_off < cand_off);
  assign chain    = (run_cnt != '0) && (right == cand_off);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.func        = cur.func;
    stat.cnt_zero    = (count == '0);
    stat.idx_zero    = (idx == '0);
    stat.match       = (rd_off == cur.frag_offset);
    stat.reach_thr   = (count >= eff_thr);
    stat.shift_more  = ((CW'(idx) + CW'(1)) < count);
    stat.run_emit    = !chain && (run_cnt > CW'(1));
    stat.run_pending = (run_cnt > CW'(1));
    stat.last_pick   = ((npick + CW'(1)) == count);
    stat.out_free    = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= wfc_pkg::THRESH_RESET;
      count      <= '0;
      cand_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (cmd.ins_write && count < HoldMaxC) count <= count + CW'(1);
      else if (cmd.cnt_dec) count <= count - CW'(1);
      else if (cmd.cnt_clr) count <= '0;
      if (cmd.pick_init) cand_valid <= 1'b0;
      else if (cmd.pick_step && better) cand_valid <= 1'b1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur  <= in_item;
      miss <= 1'b0;
    end
    if (cmd.set_miss) miss <= 1'b1;
    if (cmd.ins_write && count < HoldMaxC) begin
      offs[count[IdxW-1:0]]  <= cur.frag_offset;
      sizes[count[IdxW-1:0]] <= cur.frag_size;
    end
    if (cmd.idx_top || cmd.pick_init) idx <= IdxW'(count - CW'(1));
    else if (cmd.idx_dec) idx <= idx - IdxW'(1);
    else if (cmd.rm_shift) idx <= idx1;
    if (cmd.rm_shift) begin
      offs[idx]  <= offs[idx1];
      sizes[idx] <= sizes[idx1];
    end
    if (cmd.pick_clear) begin
      consumed <= '0;
      npick    <= '0;
      run_cnt  <= '0;
    end
    if (cmd.pick_step && better) begin
      cand_idx  <= idx;
      cand_off  <= rd_off;
      cand_size <= rd_size;
    end
    if (cmd.merge) begin
      consumed[cand_idx] <= 1'b1;
      npick <= npick + CW'(1);
      if (chain) begin
        right   <= right + cand_size;
        run_cnt <= run_cnt + CW'(1);
      end else begin
        left    <= cand_off;
        right   <= cand_off + cand_size;
        run_cnt <= CW'(1);
      end
    end
    if (cmd.emit) begin
      out_item.kind <= cmd.emit_kind;
      out_item.last <= cmd.emit_last;
      case (cmd.emit_kind)
        wfc_pkg::KIND_RUN: begin
          out_item.status     <= 1'b0;
          out_item.run_offset <= left;
          out_item.run_length <= right - left;
          out_item.run_count  <= run_cnt;
        end
        wfc_pkg::KIND_DONE: begin
          out_item.status     <= 1'b0;
          out_item.run_offset <= '0;
          out_item.run_length <= '0;
          out_item.run_count  <= count;
        end
        default: begin
          out_item.status     <= miss;
          out_item.run_offset <= '0;
          out_item.run_length <= '0;
          out_item.run_count  <= count;
        end
      endcase
    end
  end

endmodule

// ===== src/write_fragment_coalescer_core.sv =====
// Flush: selection sort over held entries up to the done result, also when an insert
// triggers it (each pick scans every held entry once through one read port).
// Output stalls delay the results.
// Throughput: one item at a time; next item taken after its last result loads.
// Reset (rst, synchronous, high): count 0, threshold 8, output empty.
`include "write_fragment_coalescer_core_assert.svh"

module write_fragment_coalescer_core #(
  parameter int DEPTH = wfc_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wfc_pkg::out_item_t out_item
);

  localparam int HoldMax = (DEPTH < 16) ? DEPTH : 16;

  wfc_pkg::cmd_t    cmd;
  wfc_pkg::status_t stat;

  // sequencer: dispatch, remove scan/shift, flush pick/merge, result emit
  wfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // fragment store, run tracker and output register
  wfc_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  `WFC_ASSERT_IMP(a_count_bound, out_valid, out_item.run_count <= 5'(HoldMax))
  `WFC_ASSERT_IMP(a_ack_last, out_valid && out_item.kind == wfc_pkg::KIND_ACK,
                  out_item.last)
  `WFC_ASSERT_IMP(a_run_shape, out_valid && out_item.kind == wfc_pkg::KIND_RUN,
                  out_item.run_count >= 5'd2 && !out_item.last)
  `WFC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

// ===== tb/write_fragment_coalescer_core_tb.sv =====
module write_fragment_coalescer_core_tb;

  // Store capacity as the block sees it: the smaller of DEPTH and 16.
  localparam int HOLD_CAP = 16;
  // Cycles without any accepted item before the run is declared hung.
  // Receiver stall runs lengthen a full flush.
  localparam int WATCHDOG_LIMIT = 20000;
  // Settling time after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [4:0]          cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  wfc_pkg::in_item_t   in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wfc_pkg::out_item_t  out_item;

  write_fragment_coalescer_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // Shadow copy of the fragment store and the threshold register.
  logic [31:0] frag_ofs_shadow[HOLD_CAP];
  logic [31:0] frag_len_shadow[HOLD_CAP];
  int unsigned frag_count_shadow = 0;
  logic [4:0]  threshold_shadow = wfc_pkg::THRESH_RESET;

  // Results still owed by the block, oldest first.
  wfc_pkg::out_item_t owed_results[$];

  int errors = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  function automatic wfc_pkg::out_item_t make_result(logic [1:0] kind, logic status,
                                                     logic [31:0] ofs, logic [31:0] len,
                                                     logic [4:0] cnt);
    wfc_pkg::out_item_t r;
    r.kind = kind;
    r.status = status;
    r.run_offset = ofs;
    r.run_length = len;
    r.run_count = cnt;
    r.last = 1'b0;
    return r;
  endfunction

  // Sort held fragments by offset (newest first on ties), report each
  // contiguous run of two or more, then the done result. Store empties.
  function automatic void coalesce_held(ref wfc_pkg::out_item_t res[$]);
    logic [31:0] so[HOLD_CAP];
    logic [31:0] ss[HOLD_CAP];
    logic [31:0] o, s, left, right;
    int n, j, cnt;
    n = frag_count_shadow;
    left = '0;
    right = '0;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      so[i] = frag_ofs_shadow[n - 1 - i];
      ss[i] = frag_len_shadow[n - 1 - i];
    end
    for (int i = 1; i < n; i++) begin
      o = so[i];
      s = ss[i];
      j = i;
      while (j > 0 && so[j - 1] > o) begin
        so[j] = so[j - 1];
        ss[j] = ss[j - 1];
        j--;
      end
      so[j] = o;
      ss[j] = s;
    end
    for (int i = 0; i < n; i++) begin
      if (cnt != 0 && right == so[i]) begin
        right = right + ss[i];
        cnt++;
      end else begin
        if (cnt > 1)
          res.push_back(make_result(wfc_pkg::KIND_RUN, 1'b0, left, right - left,
                                    cnt[4:0]));
        left = so[i];
        right = left + ss[i];
        cnt = 1;
      end
    end
    if (cnt > 1)
      res.push_back(make_result(wfc_pkg::KIND_RUN, 1'b0, left, right - left, cnt[4:0]));
    res.push_back(make_result(wfc_pkg::KIND_DONE, 1'b0, '0, '0, n[4:0]));
    frag_count_shadow = 0;
  endfunction

  // Work out every result one accepted item causes and queue them.
  function automatic void predict_results(wfc_pkg::in_item_t it);
    wfc_pkg::out_item_t res[$];
    int unsigned thr;
    logic status;
    status = 1'b1;
    case (it.func)
      wfc_pkg::FUNC_INSERT: begin
        thr = threshold_shadow;
        if (thr < 1) thr = 1;
        if (thr > HOLD_CAP) thr = HOLD_CAP;
        if (frag_count_shadow < HOLD_CAP) begin
          frag_ofs_shadow[frag_count_shadow] = it.frag_offset;
          frag_len_shadow[frag_count_shadow] = it.frag_size;
          frag_count_shadow++;
        end
        if (frag_count_shadow >= thr) coalesce_held(res);
        else res.push_back(make_result(wfc_pkg::KIND_ACK, 1'b0, '0, '0,
                                       frag_count_shadow[4:0]));
      end
      wfc_pkg::FUNC_REMOVE: begin
        // newest match goes; later entries close the gap
        for (int i = frag_count_shadow; i > 0; i--) begin
          if (frag_ofs_shadow[i - 1] == it.frag_offset) begin
            for (int m = i - 1; m + 1 < frag_count_shadow; m++) begin
              frag_ofs_shadow[m] = frag_ofs_shadow[m + 1];
              frag_len_shadow[m] = frag_len_shadow[m + 1];
            end
            frag_count_shadow--;
            status = 1'b0;
            break;
          end
        end
        res.push_back(make_result(wfc_pkg::KIND_ACK, status, '0, '0,
                                  frag_count_shadow[4:0]));
      end
      wfc_pkg::FUNC_FLUSH: coalesce_held(res);
      default: res.push_back(make_result(wfc_pkg::KIND_ACK, 1'b0, '0, '0,
                                         frag_count_shadow[4:0]));
    endcase
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) owed_results.push_back(res[i]);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%t: %s", $time, msg);
  endfunction

  // Receiver side: random stall, drawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker plus hang watchdog.
  always @(posedge clk) begin
    wfc_pkg::out_item_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          note_error($sformatf("result with nothing owed: %p", out_item));
        end else begin
          exp_r = owed_results.pop_front();
          if (out_item.kind !== exp_r.kind || out_item.status !== exp_r.status ||
              out_item.run_offset !== exp_r.run_offset ||
              out_item.run_length !== exp_r.run_length ||
              out_item.run_count !== exp_r.run_count || out_item.last !== exp_r.last)
            note_error($sformatf("mismatch: expected %p, got %p", exp_r, out_item));
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("write_fragment_coalescer_core_tb failed");
        $finish;
      end
    end
  end

  // Present one item, hold it until taken, then predict what it causes.
  task automatic send_item(logic [1:0] func, logic [31:0] ofs, logic [31:0] len);
    wfc_pkg::in_item_t it;
    it.func = func;
    it.frag_offset = ofs;
    it.frag_size = len;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_results(it);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [4:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_shadow = value;
  endtask

  // Contiguous fragments in shuffled order, sometimes closed by a flush.
  task automatic send_chain();
    logic [31:0] offs[$];
    logic [31:0] lens[$];
    logic [31:0] cur, tmp;
    int k, j;
    k = $urandom_range(2, 6);
    cur = $urandom;
    for (int i = 0; i < k; i++) begin
      offs.push_back(cur);
      lens.push_back(($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 64));
      cur = cur + lens[i];
    end
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = offs[i]; offs[i] = offs[j]; offs[j] = tmp;
      tmp = lens[i]; lens[i] = lens[j]; lens[j] = tmp;
    end
    foreach (offs[i]) send_item(wfc_pkg::FUNC_INSERT, offs[i], lens[i]);
    if ($urandom_range(2) == 0) send_item(wfc_pkg::FUNC_FLUSH, $urandom, $urandom);
  endtask

  // Field extremes and a clean run with a tied offset, at reset threshold 8.
  task automatic test_field_extremes();
    send_item(wfc_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(wfc_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(wfc_pkg::FUNC_INSERT, 32'hFFFF_FFF0, 32'h0000_0010);
    send_item(wfc_pkg::FUNC_INSERT, 32'd120, 32'd30);
    send_item(wfc_pkg::FUNC_INSERT, 32'd100, 32'd20);
    send_item(wfc_pkg::FUNC_INSERT, 32'd120, 32'd7);
    send_item(wfc_pkg::FUNC_INSERT, 32'd150, 32'd5);
    // eighth insert hits the reset threshold and flushes
    send_item(wfc_pkg::FUNC_INSERT, 32'd155, 32'hFFFF_FFFF);
  endtask

  // Remove newest of duplicates, remove with no match, unused code.
  task automatic test_remove_cases();
    send_item(wfc_pkg::FUNC_INSERT, 32'hA5A5_0000, 32'd8);
    send_item(wfc_pkg::FUNC_INSERT, 32'h5A5A_0000, 32'd8);
    send_item(wfc_pkg::FUNC_INSERT, 32'hA5A5_0000, 32'd16);
    send_item(wfc_pkg::FUNC_REMOVE, 32'hA5A5_0000, '0);
    send_item(wfc_pkg::FUNC_REMOVE, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(wfc_pkg::FUNC_FLUSH, '0, '0);
  endtask

  task automatic test_empty_flush();
    send_item(wfc_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(wfc_pkg::FUNC_REMOVE, 32'd0, 32'd0);
  endtask

  // Threshold zero acts as one; threshold one flushes on each insert too.
  task automatic test_low_thresholds();
    write_threshold(5'd0);
    send_item(wfc_pkg::FUNC_INSERT, 32'd64, 32'd64);
    send_item(wfc_pkg::FUNC_INSERT, 32'd128, 32'd64);
    write_threshold(5'd1);
    send_item(wfc_pkg::FUNC_INSERT, 32'd256, 32'd1);
  endtask

  // Mostly well-formed traffic: chains, removes of held fragments, flushes.
  task automatic test_random_traffic(logic [4:0] thr, int count);
    int target, r;
    write_threshold(thr);
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 45) send_chain();
      else if (r < 65 && frag_count_shadow > 0)
        send_item(wfc_pkg::FUNC_REMOVE,
                  frag_ofs_shadow[$urandom_range(frag_count_shadow - 1)], $urandom);
      else if (r < 73) send_item(wfc_pkg::FUNC_FLUSH, $urandom, $urandom);
      else if (r < 83) send_item(wfc_pkg::FUNC_REMOVE, $urandom, $urandom);
      else if (r < 97) send_item(wfc_pkg::FUNC_INSERT, $urandom, $urandom);
      else send_item(2'd3, $urandom, $urandom);
      // hold off mid-phase until the block has answered everything
      if (items_sent >= target - count / 2 && items_sent < target - count / 2 + 6) begin
        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    send_idle_pct = 6;
    recv_stall_pct = 88;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_remove_cases();
    test_empty_flush();
    test_low_thresholds();
    // threshold above capacity behaves as capacity
    test_random_traffic(5'd31, 135);
    send_idle_pct = 88;
    recv_stall_pct = 6;
    test_random_traffic(5'd16, 135);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(5'd5, 135);
    drain();
    if (errors == 0) begin
      $display("write_fragment_coalescer_core_tb passed");
    end else begin
      $display("write_fragment_coalescer_core_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/wfc_pkg.sv
src/wfc_ctrl.sv
src/wfc_datapath.sv
src/write_fragment_coalescer_core.sv
tb/write_fragment_coalescer_core_tb.sv
